@@ rtl/mpp_pkg.sv @@
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared codes and register layout of the median edge detector predictor.
// ----------------------------------------------------------------------------
package mpp_pkg;

  // configuration port layout
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_t;

  localparam logic                    MODE_ENCODE  = 1'b0;
  localparam logic                    MODE_DECODE  = 1'b1;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1;

endpackage

@@ rtl/mpp_predict.sv @@
// ----------------------------------------------------------------------------
// mpp_predict
// MED prediction from left, above and upper-left neighbors, then residual
// (encode) or clamped reconstruction (decode).
// ----------------------------------------------------------------------------
module mpp_predict #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                   mode,
  input  logic [SAMPLE_BITS-1:0] a,
  input  logic [SAMPLE_BITS-1:0] b,
  input  logic [SAMPLE_BITS-1:0] c,
  input  logic [SAMPLE_BITS:0]   d,
  output logic [SAMPLE_BITS-1:0] x,
  output logic [SAMPLE_BITS:0]   res,
  output logic                   err
);
  import mpp_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  logic [SAMPLE_BITS-1:0] mx;
  logic [SAMPLE_BITS-1:0] mn;
  logic [SAMPLE_BITS-1:0] p;
  logic [SAMPLE_BITS+1:0] grad;
  logic [SAMPLE_BITS+1:0] recon;

  always_comb begin
    mx   = (a > b) ? a : b;
    mn   = (a < b) ? a : b;
    // a + b - c lies between min and max here, so the low bits are exact
    grad = {2'b00, a} + {2'b00, b} - {2'b00, c};
    if (c >= mx) begin
      p = mn;
    end else if (c <= mn) begin
      p = mx;
    end else begin
      p = grad[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    recon = {d[SAMPLE_BITS], d} + {2'b00, p};
    err   = 1'b0;
    if (mode == MODE_DECODE) begin
      if (recon[SAMPLE_BITS+1]) begin
        x   = '0;
        err = 1'b1;
      end else if (recon[SAMPLE_BITS]) begin
        x   = SMAX;
        err = 1'b1;
      end else begin
        x = recon[SAMPLE_BITS-1:0];
      end
      res = {1'b0, x};
    end else begin
      // negative samples are taken as zero
      x   = d[SAMPLE_BITS] ? '0 : d[SAMPLE_BITS-1:0];
      res = {1'b0, x} - {1'b0, p};
    end
  end

endmodule

@@ rtl/med_pixel_predictor_top.sv @@
// ----------------------------------------------------------------------------
// med_pixel_predictor_top
// Raster-order JPEG-LS MED predictor with line store, encode and decode.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready   in_tdata: data_in
//   out_     out  out_tvalid/out_tready out_tdata: data_out, out_tuser:
//                                       range_error, out_tlast: end_of_image
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one pixel per clock sustained while the output does not stall; each input
// transfer is registered with its store read, then predicted into out reg.
// the single-port-per-direction line store sets the rate: one read at
// input transfer, one write when the pixel moves to the output register.
// rst_n is synchronous; no clearing pass is needed after reset.
// a stalled output holds the stage behind it and input tready drops.
// ----------------------------------------------------------------------------
module med_pixel_predictor_top #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // data_in [SAMPLE_BITS:0], zero fill above
  input  logic [((SAMPLE_BITS+8)/8)*8-1:0]    in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // data_out [SAMPLE_BITS:0], zero fill above
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]    out_tdata,
  // range_error [0]
  output logic                                out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mpp_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 8) / 8) * 8;
  localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP    = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

  // configuration
  logic                    cfg_mode_r;
  logic [WIDTH_REG_W-1:0]  cfg_width_r;
  logic [HEIGHT_REG_W-1:0] cfg_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= MODE_ENCODE;
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODE:   cfg_mode_r   <= cfg_data[0];
        CFG_WIDTH:  cfg_width_r  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_HEIGHT: cfg_height_r <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_xfer;
  logic s1_valid_r;
  logic s1_adv;
  logic out_valid_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // raster position of the next pixel
  logic [CW-1:0]           col_r;
  logic [HEIGHT_REG_W-1:0] row_r;
  logic                    col_wrap;
  logic                    row_wrap;
  logic [WCMP-1:0]         col_inc;
  logic [HEIGHT_REG_W:0]   row_inc;

  always_comb begin
    col_inc  = WCMP'(col_r) + WCMP'(1);
    row_inc  = {1'b0, row_r} + (HEIGHT_REG_W + 1)'(1);
    // width of zero behaves as one, widths past the store as the store size
    col_wrap = (col_inc >= WCMP'(cfg_width_r)) || (col_r == COL_LAST);
    row_wrap = row_inc >= {1'b0, cfg_height_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_inc[HEIGHT_REG_W-1:0];
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  // input stage
  logic [SAMPLE_BITS:0]    s1_data_r;
  logic [CW-1:0]           s1_col_r;
  logic                    s1_col_nz_r;
  logic                    s1_row_nz_r;
  logic                    s1_eoi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r   <= in_tdata[SAMPLE_BITS:0];
      s1_col_r    <= col_r;
      s1_col_nz_r <= (col_r != '0);
      s1_row_nz_r <= (row_r != '0);
      s1_eoi_r    <= col_wrap && row_wrap;
    end
  end

  // line store
  logic [SAMPLE_BITS-1:0] row_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] mem_q_r;
  logic [SAMPLE_BITS-1:0] fwd_q_r;
  logic                   fwd_r;
  logic [SAMPLE_BITS-1:0] pred_x;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_mem[s1_col_r] <= pred_x;
    end
    if (in_xfer) begin
      mem_q_r <= row_mem[col_r];
    end
  end

  // read of the column being written in the same cycle takes the new pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_xfer) begin
      fwd_r <= s1_adv && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_q_r <= pred_x;
    end
  end

  // neighbors
  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] ul_r;
  logic [SAMPLE_BITS-1:0] nb_a;
  logic [SAMPLE_BITS-1:0] nb_b;
  logic [SAMPLE_BITS-1:0] nb_c;

  always_comb begin
    nb_a = s1_col_nz_r ? left_r : '0;
    nb_b = s1_row_nz_r ? (fwd_r ? fwd_q_r : mem_q_r) : '0;
    nb_c = (s1_col_nz_r && s1_row_nz_r) ? ul_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (s1_adv) begin
      left_r <= pred_x;
      ul_r   <= nb_b;
    end
  end

  logic [SAMPLE_BITS:0] pred_res;
  logic                 pred_err;

  mpp_predict #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_predict (
    .mode (cfg_mode_r),
    .a    (nb_a),
    .b    (nb_b),
    .c    (nb_c),
    .d    (s1_data_r),
    .x    (pred_x),
    .res  (pred_res),
    .err  (pred_err)
  );

  // output register
  logic [SAMPLE_BITS:0] out_data_r;
  logic                 out_err_r;
  logic                 out_eoi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= pred_res;
      out_err_r  <= pred_err;
      out_eoi_r  <= s1_eoi_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_eoi_r;

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("pixel left the input stage without reaching the output");

  a_eoi_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && col_wrap && row_wrap) |=> (col_r == '0) && (row_r == '0))
    else $error("position did not return to origin after last pixel");

  a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("column beyond line store");

  a_err_decode_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (cfg_mode_r == MODE_DECODE))
    else $error("range error flagged while encoding");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_col_r))
    else $error("stalled input stage changed");
`endif

endmodule
